// File: rtl/mf7_pkg.sv
package mf7_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int WW        = 11;
  localparam int HW        = 12;
  localparam int RW        = 13;
  localparam int NBANK     = 6;
  localparam int WIN       = 7;
  localparam int HALF      = 3;
  localparam int NTAP      = 49;
  localparam int RANK      = 25;
  localparam int QDEPTH    = 4;
  localparam int ODEPTH    = 4;
  localparam int QCW       = $clog2(QDEPTH + 1);
  localparam int MIN_SIZE  = 4;

  typedef logic [23:0] pix_t;
  typedef pix_t [WIN-1:0] col_t;
  typedef col_t [WIN-1:0] win_t;

  typedef struct packed {
    logic [WW-1:0] w;
    logic [HW-1:0] h;
  } dims_t;

  typedef struct packed {
    win_t          win;
    logic [AW-1:0] col;
    logic          row_end;
    logic          eof_row;
  } job_t;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       last;
    logic       eof;
  } res_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  function automatic logic [2:0] mod6(input logic [4:0] v);
    logic [4:0] a;
    a = v;
    for (int i = 0; i < 4; i++) begin
      if (a >= 5'd6) a = a - 5'd6;
    end
    return a[2:0];
  endfunction

endpackage

// File: rtl/mf7_front.sv
module mf7_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   restart,
  input  mf7_pkg::dims_t         dims,
  input  logic                   push,
  output logic                   full,
  input  logic                   kind,
  input  logic [7:0]             pixel_c0,
  input  logic [7:0]             pixel_c1,
  input  logic [7:0]             pixel_c2,
  input  logic [mf7_pkg::QCW-1:0] q_count,
  output logic                   job_valid,
  output mf7_pkg::job_t          job
);
  import mf7_pkg::*;

  localparam int XW = RW + 2;

  logic [RW-1:0] row_r, row_nxt, h_ext;
  logic [AW-1:0] col_r, col_nxt;
  logic [2:0]    rmod_r, rmod_nxt, hm_r;
  logic          acc, act, in_frame;
  pix_t          pix;

  logic signed [XW-1:0] row_s, hm1_s;
  logic signed [XW-1:0] x_k [WIN];
  logic signed [XW-1:0] q_k [WIN];
  logic [WIN-1:0]       sel_k;
  logic [2:0]           bank_k [WIN];

  logic          a_v_r, a_emit_r, a_rowend_r, a_eofrow_r;
  logic [AW-1:0] a_col_r;
  pix_t          a_pix_r;
  logic [WIN-1:0] a_sel_r;
  logic [2:0]    a_bank_r [WIN];

  logic [23:0]   mem [NBANK][MAX_WIDTH];
  pix_t          rdata_r [NBANK];

  col_t          col_in;
  win_t          win_r, win_nxt;
  logic [QCW:0]  pend;

  assign pix      = {pixel_c2, pixel_c1, pixel_c0};
  assign h_ext    = RW'(dims.h);
  assign in_frame = row_r < h_ext;
  assign pend     = (QCW+1)'(q_count) + (QCW+1)'(a_v_r && a_emit_r);
  assign full     = pend >= (QCW+1)'(QDEPTH);
  assign acc      = push && !full;
  assign act      = acc && !(kind && in_frame);

  assign row_s = $signed(XW'(row_r));
  assign hm1_s = $signed(XW'(dims.h)) - $signed(XW'(1));

  // source row of each window tap, reflect-101 at top and bottom
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      x_k[k] = row_s + $signed(XW'(k)) - $signed(XW'(WIN - 1));
      if (x_k[k] < 0) begin
        q_k[k]    = -x_k[k];
        bank_k[k] = mod6(5'd12 - 5'(rmod_r) - 5'(k));
      end else if (x_k[k] > hm1_s) begin
        q_k[k]    = hm1_s + hm1_s - x_k[k];
        bank_k[k] = mod6(5'd12 + {1'b0, hm_r, 1'b0} - 5'(rmod_r) - 5'(k));
      end else begin
        q_k[k]    = x_k[k];
        bank_k[k] = mod6(5'(rmod_r) + 5'(k));
      end
      sel_k[k] = (q_k[k] == row_s) && in_frame;
    end
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    rmod_nxt = rmod_r;
    if (restart) begin
      row_nxt  = '0;
      col_nxt  = '0;
      rmod_nxt = '0;
    end else if (act) begin
      if (RW'(col_r) + RW'(1) >= RW'(dims.w)) begin
        col_nxt = '0;
        if (row_r + RW'(1) >= h_ext + RW'(HALF)) begin
          row_nxt  = '0;
          rmod_nxt = '0;
        end else begin
          row_nxt  = row_r + RW'(1);
          rmod_nxt = (rmod_r == 3'(NBANK - 1)) ? 3'd0 : rmod_r + 3'd1;
        end
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      rmod_r <= '0;
      hm_r   <= '0;
      a_v_r  <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      rmod_r <= rmod_nxt;
      if (act && row_r == h_ext - RW'(1)) hm_r <= rmod_r;
      a_v_r  <= act && (row_r >= RW'(HALF));
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      a_emit_r   <= (row_r >= RW'(HALF)) && (col_r >= AW'(HALF));
      a_rowend_r <= RW'(col_r) == RW'(dims.w) - RW'(1);
      a_eofrow_r <= row_r == h_ext + RW'(HALF - 1);
      a_col_r    <= col_r;
      a_pix_r    <= pix;
      a_sel_r    <= sel_k;
      for (int k = 0; k < WIN; k++) a_bank_r[k] <= bank_k[k];
    end
  end

  // line store, one bank per row modulo six, read before write
  always_ff @(posedge clk) begin
    for (int b = 0; b < NBANK; b++) begin
      if (act && in_frame && rmod_r == 3'(b)) mem[b][col_r] <= pix;
      rdata_r[b] <= mem[b][col_r];
    end
  end

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      col_in[k] = a_sel_r[k] ? a_pix_r : rdata_r[a_bank_r[k]];
    end
  end

  assign win_nxt = {win_r[WIN-2:0], col_in};

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win_r <= '0;
    end else if (a_v_r) begin
      win_r <= win_nxt;
    end
  end

  assign job_valid   = a_v_r && a_emit_r;
  assign job.win     = win_nxt;
  assign job.col     = a_col_r;
  assign job.row_end = a_rowend_r;
  assign job.eof_row = a_eofrow_r;

endmodule

// File: rtl/mf7_jobq.sv
module mf7_jobq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  mf7_pkg::job_t           wr_job,
  input  logic                    rd_en,
  output mf7_pkg::job_t           head,
  output logic                    q_empty,
  output logic [mf7_pkg::QCW-1:0] count
);
  import mf7_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t           slot_r [QDEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + QCW'(1);
    if (!wr_en && rd_en) cnt_nxt = cnt_r - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + PW'(1);
      if (rd_en) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wp_r] <= wr_job;
  end

  assign head    = slot_r[rp_r];
  assign q_empty = cnt_r == '0;
  assign count   = cnt_r;

endmodule

// File: rtl/mf7_back.sv
module mf7_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mf7_pkg::dims_t dims,
  input  mf7_pkg::job_t  head,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output mf7_pkg::res_t  res
);
  import mf7_pkg::*;

  localparam int XW = WW + 2;
  localparam int OW = $clog2(ODEPTH);
  localparam int OCW = $clog2(ODEPTH + 1);

  typedef struct packed {
    logic                           valid;
    logic                           last;
    logic                           eof;
    logic [2:0][NTAP-1:0][7:0]      v;
    logic [2:0][NTAP-1:0]           elig;
    logic [2:0][5:0]                t;
    logic [2:0][7:0]                m;
  } stg_t;

  // one radix step: fixes one median bit per channel
  function automatic stg_t step(input stg_t s, input int b);
    logic [NTAP-1:0] z;
    logic [5:0]      cnt;
    stg_t            o;
    o = s;
    for (int ch = 0; ch < 3; ch++) begin
      for (int n = 0; n < NTAP; n++) z[n] = s.elig[ch][n] & ~s.v[ch][n][b];
      cnt = 6'($countones(z));
      if (s.t[ch] <= cnt) begin
        o.elig[ch]  = z;
        o.m[ch][b]  = 1'b0;
      end else begin
        o.elig[ch]  = s.elig[ch] & ~z;
        o.m[ch][b]  = 1'b1;
        o.t[ch]     = s.t[ch] - cnt;
      end
    end
    return o;
  endfunction

  stg_t          stg_r [9];
  stg_t          s0_nxt;
  logic [1:0]    s_r, s_nxt;
  logic          is_last, fire, adv, opush, opop;
  logic [WW-1:0] x;
  logic signed [XW-1:0] wm1_s;
  logic signed [XW-1:0] v_j [WIN];
  logic [2:0]    age_j [WIN];

  res_t           ores_r [ODEPTH];
  logic [OW-1:0]  wp_r, rp_r;
  logic [OCW-1:0] ocnt_r;

  assign is_last = s_r == (head.row_end ? 2'd3 : 2'd0);
  assign x       = (s_r == 2'd0) ? WW'(head.col) - WW'(HALF)
                                 : dims.w - WW'(MIN_SIZE) + WW'(s_r);
  assign wm1_s   = $signed(XW'(dims.w)) - $signed(XW'(1));
  assign fire    = adv && !q_empty;
  assign q_pop   = fire && is_last;
  assign s_nxt   = fire ? (is_last ? 2'd0 : s_r + 2'd1) : s_r;

  // column of each tap, reflect-101 at left and right
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      v_j[j] = $signed(XW'(x)) + $signed(XW'(j)) - $signed(XW'(HALF));
      if (v_j[j] < 0) v_j[j] = -v_j[j];
      if (v_j[j] > wm1_s) v_j[j] = wm1_s + wm1_s - v_j[j];
      age_j[j] = 3'(head.col - v_j[j][AW-1:0]);
    end
  end

  always_comb begin
    s0_nxt       = '0;
    s0_nxt.valid = fire;
    s0_nxt.last  = is_last;
    s0_nxt.eof   = head.eof_row && (x == dims.w - WW'(1));
    for (int ch = 0; ch < 3; ch++) begin
      s0_nxt.elig[ch] = '1;
      s0_nxt.t[ch]    = 6'(RANK);
      for (int j = 0; j < WIN; j++) begin
        for (int k = 0; k < WIN; k++) begin
          s0_nxt.v[ch][j*WIN+k] = head.win[age_j[j]][k][8*ch +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0].valid <= 1'b0;
      s_r            <= '0;
    end else if (adv) begin
      stg_r[0] <= s0_nxt;
      s_r      <= s_nxt;
    end
  end

  for (genvar i = 1; i < 9; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[i].valid <= 1'b0;
      end else if (adv) begin
        stg_r[i] <= step(stg_r[i-1], 8 - i);
      end
    end
  end

  assign opop  = pop && (ocnt_r != '0);
  assign adv   = !stg_r[8].valid || (ocnt_r != OCW'(ODEPTH)) || opop;
  assign opush = adv && stg_r[8].valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) wp_r <= wp_r + OW'(1);
      if (opop)  rp_r <= rp_r + OW'(1);
      if (opush && !opop) ocnt_r <= ocnt_r + OCW'(1);
      if (!opush && opop) ocnt_r <= ocnt_r - OCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      ores_r[wp_r] <= '{c0: stg_r[8].m[0], c1: stg_r[8].m[1], c2: stg_r[8].m[2],
                        last: stg_r[8].last, eof: stg_r[8].eof};
    end
  end

  assign empty = ocnt_r == '0;
  assign res   = ores_r[rp_r];

endmodule

// File: rtl/median_filter_7x7_rgb_unit.sv
// channel   handshake        payload
// input     push / full      in_kind, in_pixel_c0..c2
// result    empty / pop      out_median_c0..c2, out_last_in_run, out_end_of_frame
// config    cfg_wr_en        cfg_index, cfg_wdata
//
// one request per cycle while full is low; the last pixel of a row releases four
// results, the back end drains one result per cycle unless its output queue is
// full and unpopped, through an eight-stage radix select; a request passes the
// line store read, dispatch, one stage per median bit and the output queue
// synchronous reset clears control and the window register; the line store is not swept
// full rises when the job queue can take no more; a stalled pop holds the pipe
module median_filter_7x7_rgb_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [7:0]  in_pixel_c0,
  input  logic [7:0]  in_pixel_c1,
  input  logic [7:0]  in_pixel_c2,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_median_c0,
  output logic [7:0]  out_median_c1,
  output logic [7:0]  out_median_c2,
  output logic        out_last_in_run,
  output logic        out_end_of_frame,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  import mf7_pkg::*;

  logic [WW-1:0]  width_r;
  logic [HW-1:0]  height_r;
  dims_t          dims;
  logic           job_valid, q_empty, q_pop;
  job_t           job, head;
  logic [QCW-1:0] q_count;
  res_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(640);
      height_r <= HW'(480);
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_wdata[WW-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[HW-1:0];
      endcase
    end
  end

  always_comb begin
    if (width_r < WW'(MIN_SIZE))           dims.w = WW'(MIN_SIZE);
    else if (int'(width_r) > MAX_WIDTH)    dims.w = WW'(MAX_WIDTH);
    else                                   dims.w = width_r;
    dims.h = (height_r < HW'(MIN_SIZE)) ? HW'(MIN_SIZE) : height_r;
  end

  mf7_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_wr_en),
    .dims      (dims),
    .push      (push),
    .full      (full),
    .kind      (in_kind),
    .pixel_c0  (in_pixel_c0),
    .pixel_c1  (in_pixel_c1),
    .pixel_c2  (in_pixel_c2),
    .q_count   (q_count),
    .job_valid (job_valid),
    .job       (job)
  );

  mf7_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_valid),
    .wr_job  (job),
    .rd_en   (q_pop),
    .head    (head),
    .q_empty (q_empty),
    .count   (q_count)
  );

  mf7_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .dims    (dims),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_median_c0    = res.c0;
  assign out_median_c1    = res.c1;
  assign out_median_c2    = res.c2;
  assign out_last_in_run  = res.last;
  assign out_end_of_frame = res.eof;

`ifndef NO_ASSERTIONS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCW'(QDEPTH))
    else $error("job queue overflow");

  a_q_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == QCW'(QDEPTH)) |-> full)
    else $error("request taken with job queue full");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_end_of_frame) |-> out_last_in_run)
    else $error("frame end not on last result of its run");
`endif

endmodule

// File: bench/tb.sv
module tb;
  import mf7_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_kind = 1'b0;
  logic [7:0]  in_pixel_c0 = '0, in_pixel_c1 = '0, in_pixel_c2 = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_median_c0, out_median_c1, out_median_c2;
  logic        out_last_in_run, out_end_of_frame;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  median_filter_7x7_rgb_unit dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic       kind;
    logic [7:0] c0, c1, c2;
  } pix_req_t;

  pix_req_t pending_q[$];
  res_t     median_q[$];

  // filter image of the design
  logic [10:0] width_reg;
  logic [11:0] height_reg;
  pix_t        rows_mem [0:NBANK*MAX_WIDTH-1];
  pix_t        cols_win [0:WIN-1][0:WIN-1];
  int          pos_row, pos_col;

  int  errors = 0;
  int  results_seen = 0;
  int  frames_done = 0;
  bit  calm = 1'b0;
  int  push_gap = 0, pop_gap = 0;

  function automatic int dim_w();
    int v;
    v = width_reg;
    if (v < MIN_SIZE) v = MIN_SIZE;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return v;
  endfunction

  function automatic int dim_h();
    int v;
    v = height_reg;
    if (v < MIN_SIZE) v = MIN_SIZE;
    return v;
  endfunction

  function automatic int reflect(int x, int n);
    if (x < 0) x = -x;
    if (x > n - 1) x = 2 * (n - 1) - x;
    if (x < 0) x = 0;
    if (x > n - 1) x = n - 1;
    return x;
  endfunction

  task automatic clear_frame();
    for (int a = 0; a < WIN; a++)
      for (int k = 0; k < WIN; k++) cols_win[a][k] = '0;
    pos_row = 0;
    pos_col = 0;
  endtask

  task automatic add_median(int x, int c, int w, int h, int r_out);
    int   hist [3][256];
    int   col, age, acc;
    res_t e;
    pix_t v;
    logic [7:0] m [3];
    for (int ch = 0; ch < 3; ch++)
      for (int i = 0; i < 256; i++) hist[ch][i] = 0;
    for (int j = 0; j < WIN; j++) begin
      col = reflect(x + j - HALF, w);
      age = c - col;
      if (age < 0 || age > 6) age = 0;
      for (int k = 0; k < WIN; k++) begin
        v = cols_win[age][k];
        hist[0][v[7:0]]++;
        hist[1][v[15:8]]++;
        hist[2][v[23:16]]++;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      m[ch] = 8'd255;
      for (int i = 0; i < 256; i++) begin
        acc += hist[ch][i];
        if (acc >= RANK) begin
          m[ch] = i[7:0];
          break;
        end
      end
    end
    e.c0 = m[0];
    e.c1 = m[1];
    e.c2 = m[2];
    e.last = 1'b0;
    e.eof = (r_out == h - 1 && x == w - 1);
    if (e.eof) frames_done++;
    median_q.push_back(e);
  endtask

  task automatic predict_medians(pix_req_t rq);
    int   w, h, r, c, q;
    pix_t pix;
    col_t column;
    res_t e;
    w = dim_w();
    h = dim_h();
    r = pos_row;
    c = pos_col;
    pix = {rq.c2, rq.c1, rq.c0};
    if (r >= h + 3 || c >= w) begin
      clear_frame();
      r = 0;
      c = 0;
    end
    if (rq.kind && r < h) return;
    if (r >= 3) begin
      for (int k = 0; k < WIN; k++) begin
        q = reflect(r - 6 + k, h);
        column[k] = (q == r && r < h) ? pix : rows_mem[(q % NBANK) * MAX_WIDTH + c];
      end
      for (int a = 6; a > 0; a--) cols_win[a] = cols_win[a - 1];
      for (int k = 0; k < WIN; k++) cols_win[0][k] = column[k];
    end
    if (r < h) rows_mem[(r % NBANK) * MAX_WIDTH + c] = pix;
    if (r >= 3 && c >= 3) begin
      add_median(c - 3, c, w, h, r - 3);
      if (c == w - 1)
        for (int k = 3; k >= 1; k--) add_median(w - k, c, w, h, r - 3);
      e = median_q.pop_back();
      e.last = 1'b1;
      median_q.push_back(e);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h + 3) r = 0;
    end
    pos_row = r;
    pos_col = c;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_medians({in_kind, in_pixel_c0, in_pixel_c1, in_pixel_c2});
        void'(pending_q.pop_front());
      end
      if (push && full) begin
      end else if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        push_gap = $urandom_range(1, 14);
        push <= 1'b0;
      end else if (pending_q.size() > 0) begin
        push <= 1'b1;
        in_kind <= pending_q[0].kind;
        in_pixel_c0 <= pending_q[0].c0;
        in_pixel_c1 <= pending_q[0].c1;
        in_pixel_c2 <= pending_q[0].c2;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = '{out_median_c0, out_median_c1, out_median_c2,
                out_last_in_run, out_end_of_frame};
        results_seen++;
        if (median_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result expected none actual %h", $time, got);
        end else begin
          want = median_q.pop_front();
          if (got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2 ||
              got.last !== want.last || got.eof !== want.eof) begin
            errors++;
            $display("%0t median mismatch expected c0 %h c1 %h c2 %h last %b eof %b",
                     $time, want.c0, want.c1, want.c2, want.last, want.eof);
            $display("%0t                 actual   c0 %h c1 %h c2 %h last %b eof %b",
                     $time, got.c0, got.c1, got.c2, got.last, got.eof);
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        pop_gap = $urandom_range(1, 14);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || push) @(posedge clk);
    while (median_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [11:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val[10:0];
    else height_reg = val;
    clear_frame();
  endtask

  task automatic queue_pixel(logic kind, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    pending_q.push_back('{kind, a, b, c});
  endtask

  // whole frame plus drain, content per mode: fixed pattern, narrow spread or random
  task automatic queue_frame(int w, int h, int mode);
    logic [7:0] a, b, c;
    for (int i = 0; i < w * h; i++) begin
      case (mode)
        0: begin a = 8'h00; b = 8'hff; c = (i % 2) ? 8'hff : 8'h00; end
        1: begin a = 8'($urandom_range(0, 3)); b = 8'($urandom_range(252, 255));
                 c = 8'($urandom_range(0, 255)); end
        default: begin a = 8'($urandom); b = 8'($urandom); c = 8'($urandom); end
      endcase
      if ($urandom_range(0, 15) == 0)
        queue_pixel(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      queue_pixel(1'b0, a, b, c);
    end
    for (int i = 0; i < 3 * w; i++)
      queue_pixel($urandom_range(0, 3) != 0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    width_reg = 11'd640;
    height_reg = 12'd480;
    clear_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest frame, extremes, stray ticks, clamped sizes
    write_reg(REG_WIDTH, 12'd4);
    write_reg(REG_HEIGHT, 12'd4);
    queue_frame(4, 4, 0);
    wait_drained();
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd2);
    queue_frame(4, 4, 1);
    wait_drained();

    // random frames of various shapes
    for (int f = 0; f < 5; f++) begin
      int w, h;
      w = $urandom_range(4, 10);
      h = $urandom_range(4, 7);
      write_reg(REG_WIDTH, 12'(w));
      write_reg(REG_HEIGHT, 12'(h));
      queue_frame(w, h, 2);
      wait_drained();
    end
    calm = 1'b1;
    write_reg(REG_WIDTH, 12'd5);
    write_reg(REG_HEIGHT, 12'd5);
    queue_frame(5, 5, 2);
    wait_drained();

    $display("covered %0d results over %0d completed frames, small and clamped sizes",
             results_seen, frames_done);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
